// ----- rtl/core/csvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants shared by the field splitter: item layouts, byte codes
// and offset widths.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W    = $clog2(MAX_LINE);
    localparam int LEN_W    = POS_W + 1;
    localparam int NUM_W    = 8;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
    localparam logic [NUM_W-1:0] NUM_MAX  = '1;

    localparam logic [7:0] QUOTE_BYTE        = 8'd34;
    localparam logic [7:0] DEFAULT_SEPARATOR = 8'd44;
    localparam logic [7:0] SPACE_BYTE        = 8'd32;
    localparam logic [7:0] TAB_BYTE          = 8'd9;
    localparam logic [7:0] CR_BYTE           = 8'd13;

    localparam int RES_DEPTH = 3;
    localparam int RES_CNT_W = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] field_start;
        logic [LEN_W-1:0] field_length;
        logic [NUM_W-1:0] field_number;
        logic             last_field;
        logic             malformed;
    } out_item_t;

endpackage

// ----- rtl/core/csv_field_splitter.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a text line, one byte per item, into separator-delimited fields with
// quote handling and whitespace trimming; reports each field's offset/length.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one byte of a line per item, with line_end on the last
//   byte. m_ channel returns one item per completed field: trimmed start
//   offset, length, field index, last-field flag and malformed flag.
//   cfg_ channel writes the separator byte; it is always ready and should
//   only be written while the block is idle.
// Timing:
//   One byte is taken every cycle while s_ready is high. A field item is
//   registered into the output queue as the byte that completes it is taken.
//   A line ending in a separator gives two items from that byte, queued together.
//   Results wait in a three-entry output queue; s_ready drops while two or
//   more are held, so a stalled receiver stalls the input after two items.
// Reset:
//   Clears the queue, line position, quote tracking and field counter, and
//   sets the separator to a comma.
// ----------------------------------------------------------------------------
module csv_field_splitter
    import csvfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0]       sep_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic             inq_reg, inq_next;
    logic             saw_reg, saw_next;
    logic [POS_W-1:0] open_reg, open_next;
    logic [POS_W-1:0] close_reg, close_next;
    logic             ffv_reg, ffv_next;
    logic [POS_W-1:0] ff_reg, ff_next;
    logic [POS_W-1:0] fl_reg, fl_next;
    logic             qfv_reg, qfv_next;
    logic [POS_W-1:0] qf_reg, qf_next;
    logic [POS_W-1:0] ql_reg, ql_next;
    logic [NUM_W-1:0] fcnt_reg, fcnt_next;

    out_item_t            q_reg [RES_DEPTH];
    out_item_t            q_next [RES_DEPTH];
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept, pop;
    logic             qb, sep, sp, done, extra_field;
    logic [POS_W-1:0] pos_inc;
    logic [NUM_W-1:0] num0, num1;
    logic [1:0]       push_n;
    logic [RES_CNT_W-1:0] base;
    out_item_t        r0, r1;

    function automatic logic is_space(input logic [7:0] c);
        return (c == SPACE_BYTE) || (c >= TAB_BYTE && c <= CR_BYTE);
    endfunction

    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? p : p + POS_W'(1);
    endfunction

    function automatic logic [NUM_W-1:0] step_num(input logic [NUM_W-1:0] n);
        return (n == NUM_MAX) ? n : n + NUM_W'(1);
    endfunction

    assign accept    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign s_ready   = (cnt_reg <= RES_CNT_W'(1));
    assign m_valid   = (cnt_reg != '0);
    assign m_item    = q_reg[0];
    assign cfg_ready = 1'b1;

    always_comb begin
        qb        = (s_item.ch == QUOTE_BYTE);
        sp        = is_space(s_item.ch);
        sep       = (s_item.ch == sep_reg);
        pos_inc   = step_pos(pos_reg);

        pos_next   = pos_reg;
        begin_next = begin_reg;
        inq_next   = inq_reg;
        saw_next   = saw_reg;
        open_next  = open_reg;
        close_next = close_reg;
        ffv_next   = ffv_reg;
        ff_next    = ff_reg;
        fl_next    = fl_reg;
        qfv_next   = qfv_reg;
        qf_next    = qf_reg;
        ql_next    = ql_reg;
        fcnt_next  = fcnt_reg;

        // quote toggling comes before the separator test
        if (qb) begin
            if (inq_reg) begin
                saw_next   = 1'b1;
                close_next = pos_reg;
            end else begin
                open_next = pos_reg;
                qfv_next  = 1'b0;
            end
            inq_next = !inq_reg;
        end

        done        = (!inq_next && sep) || s_item.line_end;
        extra_field = s_item.line_end && sep;

        if (!(done && sep) && !sp) begin
            if (!ffv_next) begin
                ff_next = pos_reg;
            end
            ffv_next = 1'b1;
            fl_next  = pos_reg;
        end
        if (inq_next && !qb && !sp) begin
            if (!qfv_next) begin
                qf_next = pos_reg;
            end
            qfv_next = 1'b1;
            ql_next  = pos_reg;
        end

        num0 = fcnt_reg;
        num1 = step_num(fcnt_reg);

        r0 = '0;
        if (saw_next) begin
            if (close_next <= open_next) begin
                r0.malformed   = 1'b1;
                r0.field_start = step_pos(open_next);
            end else if (!qfv_next) begin
                r0.field_start = open_next + POS_W'(1);
            end else begin
                r0.field_start  = qf_next;
                r0.field_length = {1'b0, ql_next} - {1'b0, qf_next} + LEN_W'(1);
            end
        end else if (!ffv_next) begin
            r0.field_start = begin_reg;
        end else begin
            r0.field_start  = ff_next;
            r0.field_length = {1'b0, fl_next} - {1'b0, ff_next} + LEN_W'(1);
        end
        r0.field_number = num0;
        r0.last_field   = s_item.line_end && !extra_field;

        r1              = '0;
        r1.field_start  = pos_inc;
        r1.field_number = num1;
        r1.last_field   = 1'b1;

        if (done) begin
            fcnt_next  = extra_field ? step_num(num1) : num1;
            begin_next = pos_inc;
            saw_next   = 1'b0;
            inq_next   = 1'b0;
            ffv_next   = 1'b0;
        end

        if (s_item.line_end) begin
            pos_next   = '0;
            begin_next = '0;
            fcnt_next  = '0;
        end else begin
            pos_next = pos_inc;
        end

        push_n = !accept ? 2'd0 : (!done ? 2'd0 : (extra_field ? 2'd2 : 2'd1));
    end

    always_comb begin
        base = cnt_reg - RES_CNT_W'(pop);
        for (int i = 0; i < RES_DEPTH; i++) begin
            if (pop && i < RES_DEPTH - 1) begin
                q_next[i] = q_reg[i+1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push_n != 2'd0 && base == RES_CNT_W'(i)) begin
                q_next[i] = r0;
            end
            if (push_n == 2'd2 && base + RES_CNT_W'(1) == RES_CNT_W'(i)) begin
                q_next[i] = r1;
            end
        end
        cnt_next = base + RES_CNT_W'(push_n);
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        if (!aresetn) begin
            sep_reg   <= DEFAULT_SEPARATOR;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            inq_reg   <= 1'b0;
            saw_reg   <= 1'b0;
            open_reg  <= '0;
            close_reg <= '0;
            ffv_reg   <= 1'b0;
            ff_reg    <= '0;
            fl_reg    <= '0;
            qfv_reg   <= 1'b0;
            qf_reg    <= '0;
            ql_reg    <= '0;
            fcnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_data;
            end
            if (accept) begin
                pos_reg   <= pos_next;
                begin_reg <= begin_next;
                inq_reg   <= inq_next;
                saw_reg   <= saw_next;
                open_reg  <= open_next;
                close_reg <= close_next;
                ffv_reg   <= ffv_next;
                ff_reg    <= ff_next;
                fl_reg    <= fl_next;
                qfv_reg   <= qfv_next;
                qf_reg    <= qf_next;
                ql_reg    <= ql_next;
                fcnt_reg  <= fcnt_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_line_end_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.line_end |=> m_valid)
        else $error("line end produced no field item");

    a_line_end_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.line_end |=> pos_reg == '0 && fcnt_reg == '0 && !inq_reg)
        else $error("line state not cleared after line end");

    a_malformed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.malformed |-> m_item.field_length == '0)
        else $error("malformed field carries a length");
`endif

endmodule
